@@ rtl/u8s_pkg.sv @@
package u8s_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned QUEUE_D  = 4;
    localparam int unsigned REPL_LEN = 3;

    localparam logic [BYTE_W-1:0] REPL_B0 = 8'hEF;
    localparam logic [BYTE_W-1:0] REPL_B1 = 8'hBF;
    localparam logic [BYTE_W-1:0] REPL_B2 = 8'hBD;

    localparam logic [BYTE_W-1:0] MIN_LEAD2 = 8'hC2;
    localparam logic [15:0] MIN_CODE3  = 16'h0800;
    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [20:0] MIN_CODE4  = 21'h010000;
    localparam logic [20:0] MAX_CODE   = 21'h10FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } t_state;

    function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] lead);
        logic [2:0] len;
        len = 3'd0;
        if (lead[7] == 1'b0) begin
            len = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (lead[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] repl_byte(input logic [1:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/utf8_sanitizer_core.sv @@
// UTF-8 sanitizer. Bytes enter on the s_ stream, one per request, with s_tlast on the final
// byte of a text. Well-formed, minimally encoded sequences leave on the m_ stream unchanged;
// each byte that cannot start a valid sequence leaves as EF BF BD. m_tlast marks the final
// output byte caused by one input byte and m_tuser marks that byte when the input ended a
// text. Bytes of an incomplete sequence are held (no output) until the sequence resolves.
// Steps: the byte is taken, then each resolved lead gets an evaluation step and each output
// byte an emit step, and a closing evaluation ends the input; an input that only gets held
// goes from taking straight to the closing evaluation. A single evaluate-and-shift unit over
// a four-byte queue is reused for every step, and s_tready stays low until the closing step.
// Output back-pressure stretches the emit and closing steps.
module utf8_sanitizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser     // [0] text_done
);

    u8s_pkg::t_state r_state, n_state;

    logic [7:0] r_q [u8s_pkg::QUEUE_D];
    logic [7:0] n_shift [u8s_pkg::QUEUE_D];
    logic [2:0] r_n;
    logic       r_end;
    logic       r_rep, n_rep;
    logic [2:0] r_cnt, n_cnt;
    logic [2:0] r_drop, n_drop;
    logic [1:0] r_k;
    logic [7:0] r_pend;
    logic       r_pv;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_odone;

    logic [2:0]  c_len;
    logic [2:0]  c_have;
    logic        c_cont_fail;
    logic        c_incomplete;
    logic        c_range_ok;
    logic        c_hold;
    logic        c_bad;
    logic [15:0] c_code3;
    logic [20:0] c_code4;
    logic        c_out_free;
    logic        c_emit_go;
    logic        c_emit_last;
    logic        c_finish;
    logic        c_start;
    logic [7:0]  c_emit_byte;
    logic [2:0]  c_sidx [u8s_pkg::QUEUE_D];

    // evaluate the queue head
    always_comb begin
        c_len        = u8s_pkg::seq_len(r_q[0]);
        c_have       = (r_n < c_len) ? r_n : c_len;
        c_cont_fail  = 1'b0;
        for (int i = 1; i < u8s_pkg::QUEUE_D; i++) begin
            if ((3'(i) < c_have) && (r_q[i][7:6] != 2'b10)) begin
                c_cont_fail = 1'b1;
            end
        end
        c_incomplete = (r_n < c_len);
        c_code3      = {r_q[0][3:0], r_q[1][5:0], r_q[2][5:0]};
        c_code4      = {r_q[0][2:0], r_q[1][5:0], r_q[2][5:0], r_q[3][5:0]};
        case (c_len)
            3'd1:    c_range_ok = 1'b1;
            3'd2:    c_range_ok = (r_q[0] >= u8s_pkg::MIN_LEAD2);
            3'd3:    c_range_ok = (c_code3 >= u8s_pkg::MIN_CODE3)
                                  && ((c_code3 < u8s_pkg::SURR_LO)
                                      || (c_code3 > u8s_pkg::SURR_HI));
            3'd4:    c_range_ok = (c_code4 >= u8s_pkg::MIN_CODE4)
                                  && (c_code4 <= u8s_pkg::MAX_CODE);
            default: c_range_ok = 1'b0;
        endcase
        c_hold = 1'b0;
        if (c_len == 3'd0 || c_cont_fail) begin
            c_bad = 1'b1;
        end else if (c_incomplete) begin
            c_bad  = r_end;
            c_hold = !r_end;
        end else begin
            c_bad = !c_range_ok;
        end
        n_rep  = c_bad;
        n_cnt  = c_bad ? 3'(u8s_pkg::REPL_LEN) : c_len;
        n_drop = c_bad ? 3'd1 : c_len;
    end

    // drop consumed bytes from the queue front
    always_comb begin
        for (int i = 0; i < u8s_pkg::QUEUE_D; i++) begin
            c_sidx[i]  = 3'(i) + r_drop;
            n_shift[i] = (c_sidx[i] < 3'(u8s_pkg::QUEUE_D)) ? r_q[c_sidx[i][1:0]] : 8'h00;
        end
    end

    // step control
    always_comb begin
        c_out_free  = !r_ovalid || m_tready;
        c_emit_byte = r_rep ? u8s_pkg::repl_byte(r_k) : r_q[r_k];
        c_emit_go   = (r_state == u8s_pkg::ST_EMIT) && (!r_pv || c_out_free);
        c_emit_last = c_emit_go && (3'(r_k) + 3'd1 == r_cnt);
        c_finish    = (r_state == u8s_pkg::ST_EVAL) && ((r_n == 3'd0) || c_hold)
                      && (!r_pv || c_out_free);
        c_start     = (r_state == u8s_pkg::ST_EVAL) && (r_n != 3'd0) && !c_hold;
        s_tready    = (r_state == u8s_pkg::ST_IDLE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            u8s_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = u8s_pkg::ST_EVAL;
                end
            end
            u8s_pkg::ST_EVAL: begin
                if (c_finish) begin
                    n_state = u8s_pkg::ST_IDLE;
                end else if (c_start) begin
                    n_state = u8s_pkg::ST_EMIT;
                end
            end
            u8s_pkg::ST_EMIT: begin
                if (c_emit_last) begin
                    n_state = u8s_pkg::ST_EVAL;
                end
            end
            default: n_state = u8s_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= u8s_pkg::ST_IDLE;
            r_n      <= 3'd0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= 2'd0;
            for (int i = 0; i < u8s_pkg::QUEUE_D; i++) begin
                r_q[i] <= 8'h00;
            end
        end else begin
            r_state <= n_state;
            if (s_tvalid && s_tready) begin
                r_q[r_n[1:0]] <= s_tdata;
                r_n           <= r_n + 3'd1;
                r_end         <= s_tlast;
            end
            if (c_start) begin
                r_rep  <= n_rep;
                r_cnt  <= n_cnt;
                r_drop <= n_drop;
                r_k    <= 2'd0;
            end
            if (c_emit_go) begin
                r_k    <= r_k + 2'd1;
                r_pend <= c_emit_byte;
                r_pv   <= 1'b1;
            end
            if (c_emit_last) begin
                r_q <= n_shift;
                r_n <= r_n - r_drop;
            end
            if (c_finish) begin
                r_pv <= 1'b0;
            end
            if ((c_emit_go || c_finish) && r_pv) begin
                r_ovalid <= 1'b1;
                r_obyte  <= r_pend;
                r_olast  <= c_finish;
                r_odone  <= c_finish && r_end;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_obyte;
    assign m_tlast  = r_olast;
    assign m_tuser  = r_odone;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !r_pv)
        else $error("pending byte left over while idle");

    a_idle_held_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> (r_n <= 3'd3))
        else $error("more than three bytes held while idle");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == u8s_pkg::ST_EVAL))
        else $error("accepted byte not evaluated");

    a_drop_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_emit_last |-> (r_drop <= r_n))
        else $error("drop beyond queue fill");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("text end flag on a non-final byte");
`endif

endmodule
